FILE: sv/kmf_pkg.sv
// kmf_pkg: shared types, register indexes and message constants for the
// keybed message framer. No dependencies.

package kmf_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned LEN_W = 3;
   localparam int unsigned MSG_BYTES = 4;
   localparam int unsigned STATUS_W = 16;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 2;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_INTERFACE_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENQUEUE_GATE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DISPATCH_GATE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PROCESSOR_FLAG = 2'd3;

   // interface modes; anything at or above running acts as running
   localparam logic [1:0] MODE_IGNORE = 2'd0;
   localparam logic [1:0] MODE_HANDSHAKE = 2'd1;
   localparam logic [1:0] MODE_RUNNING = 2'd2;

   localparam int unsigned HEADER_BIT = 7;
   localparam logic [BYTE_W-1:0] CLASS_MASK = 8'hF0;
   localparam logic [BYTE_W-1:0] CLASS_ACK = 8'hA0;
   localparam logic [BYTE_W-1:0] CLASS_HEARTBEAT = 8'hE0;

   typedef struct packed {
      logic [1:0] interface_mode;
      logic       enqueue_gate;
      logic       dispatch_gate;
      logic       processor_flag;
   } cfg_type;

   typedef struct packed {
      logic [MSG_BYTES-1:0][BYTE_W-1:0] bytes;
      logic [LEN_W-1:0]                 length;
   } msg_type;

   // message length by header class (bits 6..4); class 7 frames nothing
   function automatic logic [LEN_W-1:0] length_of(input logic [2:0] cls);
      logic [LEN_W-1:0] len;
      case (cls)
         3'd0: len = 3'd3;
         3'd1: len = 3'd3;
         3'd2: len = 3'd3;
         3'd3: len = 3'd3;
         3'd4: len = 3'd1;
         3'd5: len = 3'd2;
         3'd6: len = 3'd4;
         default: len = 3'd0;
      endcase
      return len;
   endfunction

endpackage

FILE: sv/kmf_csr.sv
// kmf_csr: configuration registers written through the csr port.
// Depends on kmf_pkg.

module kmf_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [kmf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [kmf_pkg::CSR_DATA_W-1:0]   csr_write_data,
   output kmf_pkg::cfg_type                 cfg
);

   kmf_pkg::cfg_type cfg_ff;
   kmf_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            kmf_pkg::CSR_INTERFACE_MODE: cfg_in.interface_mode = csr_write_data;
            kmf_pkg::CSR_ENQUEUE_GATE:   cfg_in.enqueue_gate = csr_write_data[0];
            kmf_pkg::CSR_DISPATCH_GATE:  cfg_in.dispatch_gate = csr_write_data[0];
            kmf_pkg::CSR_PROCESSOR_FLAG: cfg_in.processor_flag = csr_write_data[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: sv/kmf_framer.sv
// kmf_framer: framing state and message byte store; flags the byte that
// completes a message and presents the assembled message. Depends on kmf_pkg.

module kmf_framer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [kmf_pkg::BYTE_W-1:0]    rx_byte,
   output logic                          done,
   output kmf_pkg::msg_type              msg
);

   logic                          in_msg_ff, in_msg_in;
   logic [kmf_pkg::LEN_W-1:0]     exp_ff, exp_in;
   logic [kmf_pkg::LEN_W-1:0]     pos_ff, pos_in;
   logic [kmf_pkg::BYTE_W-1:0]    store_ff [kmf_pkg::MSG_BYTES];

   logic                          is_header;
   logic [kmf_pkg::LEN_W-1:0]     hdr_len;
   logic [kmf_pkg::LEN_W-1:0]     cur_pos;
   logic [kmf_pkg::LEN_W-1:0]     cur_exp;
   logic [kmf_pkg::LEN_W-1:0]     next_pos;
   logic                          active;
   logic                          store_we;

   assign is_header = rx_byte[kmf_pkg::HEADER_BIT];
   assign hdr_len = kmf_pkg::length_of(rx_byte[6:4]);

   // a header restarts framing, aborting any message in progress
   assign cur_pos = is_header ? '0 : pos_ff;
   assign cur_exp = is_header ? hdr_len : exp_ff;
   assign active = is_header ? (hdr_len != '0) : in_msg_ff;
   assign next_pos = cur_pos + kmf_pkg::LEN_W'(1);
   assign done = active && (next_pos == cur_exp);
   assign store_we = accept && active;

   always_comb begin
      in_msg_in = in_msg_ff;
      exp_in = exp_ff;
      pos_in = pos_ff;
      if (accept) begin
         in_msg_in = active && !done;
         if (is_header) begin
            exp_in = hdr_len;
         end
         if (active) begin
            pos_in = next_pos;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_msg_ff <= 1'b0;
         exp_ff <= '0;
         pos_ff <= '0;
      end else begin
         in_msg_ff <= in_msg_in;
         exp_ff <= exp_in;
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[cur_pos[1:0]] <= rx_byte;
      end
   end

   // completing byte bypasses the store; bytes past the length read as zero
   always_comb begin
      for (int i = 0; i < kmf_pkg::MSG_BYTES; i++) begin
         if (kmf_pkg::LEN_W'(i) >= next_pos) begin
            msg.bytes[i] = '0;
         end else if (kmf_pkg::LEN_W'(i) == cur_pos) begin
            msg.bytes[i] = rx_byte;
         end else begin
            msg.bytes[i] = store_ff[i];
         end
      end
      msg.length = next_pos;
   end

   a_pos_below_expected : assert property (@(posedge clock) disable iff (reset)
      in_msg_ff |-> (pos_ff < exp_ff))
      else $error("framer position reached expected count while in message");

   a_done_length_range : assert property (@(posedge clock) disable iff (reset)
      (accept && done) |-> (next_pos != '0 && next_pos <= kmf_pkg::LEN_W'(kmf_pkg::MSG_BYTES)))
      else $error("completed message length out of range");

endmodule

FILE: sv/kmf_dispatch.sv
// kmf_dispatch: dispatch decisions for a completed message and the result
// register on the rsp side. Depends on kmf_pkg.

module kmf_dispatch (
   input  logic                            clock,
   input  logic                            reset,
   input  kmf_pkg::cfg_type                cfg,
   input  logic                            load,
   input  kmf_pkg::msg_type                msg,
   input  logic                            rsp_stall,
   output logic                            rsp_valid,
   output logic [kmf_pkg::BYTE_W-1:0]      rsp_byte_zero,
   output logic [kmf_pkg::BYTE_W-1:0]      rsp_byte_one,
   output logic [kmf_pkg::BYTE_W-1:0]      rsp_byte_two,
   output logic [kmf_pkg::BYTE_W-1:0]      rsp_byte_three,
   output logic [kmf_pkg::LEN_W-1:0]       rsp_msg_length,
   output logic                            rsp_enqueue,
   output logic                            rsp_heartbeat,
   output logic                            rsp_handshake_ack,
   output logic [kmf_pkg::STATUS_W-1:0]    rsp_status_word
);

   logic                            valid_ff, valid_in;
   kmf_pkg::msg_type                msg_ff;
   logic                            enqueue_ff, enqueue_in;
   logic                            heartbeat_ff, heartbeat_in;
   logic                            ack_ff, ack_in;
   logic [kmf_pkg::STATUS_W-1:0]    status_ff, status_in;

   logic [kmf_pkg::BYTE_W-1:0]      msg_class;
   logic                            handshake_mode;
   logic                            running_mode;

   assign msg_class = msg.bytes[0] & kmf_pkg::CLASS_MASK;
   assign handshake_mode = (cfg.interface_mode == kmf_pkg::MODE_HANDSHAKE);
   assign running_mode = (cfg.interface_mode >= kmf_pkg::MODE_RUNNING);

   always_comb begin
      enqueue_in = 1'b0;
      heartbeat_in = 1'b0;
      ack_in = 1'b0;
      status_in = '0;
      if (handshake_mode) begin
         if (msg_class == kmf_pkg::CLASS_ACK) begin
            ack_in = 1'b1;
            status_in = {msg.bytes[1], msg.bytes[2]};
         end
      end else if (running_mode) begin
         if (msg_class == kmf_pkg::CLASS_HEARTBEAT) begin
            heartbeat_in = 1'b1;
            enqueue_in = cfg.enqueue_gate;
         end else begin
            enqueue_in = (cfg.dispatch_gate && !cfg.processor_flag) || cfg.enqueue_gate;
         end
      end
   end

   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         msg_ff <= msg;
         enqueue_ff <= enqueue_in;
         heartbeat_ff <= heartbeat_in;
         ack_ff <= ack_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_byte_zero = msg_ff.bytes[0];
   assign rsp_byte_one = msg_ff.bytes[1];
   assign rsp_byte_two = msg_ff.bytes[2];
   assign rsp_byte_three = msg_ff.bytes[3];
   assign rsp_msg_length = msg_ff.length;
   assign rsp_enqueue = enqueue_ff;
   assign rsp_heartbeat = heartbeat_ff;
   assign rsp_handshake_ack = ack_ff;
   assign rsp_status_word = status_ff;

   a_no_load_while_held : assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rsp_stall) |-> !load)
      else $error("result overwritten while stalled");

   a_ack_heartbeat_exclusive : assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> !(ack_ff && heartbeat_ff))
      else $error("acknowledge and heartbeat both set");

   a_ack_is_ack_class : assert property (@(posedge clock) disable iff (reset)
      (valid_ff && ack_ff) |->
         ((msg_ff.bytes[0] & kmf_pkg::CLASS_MASK) == kmf_pkg::CLASS_ACK
          && msg_ff.length == 3'd3))
      else $error("acknowledge on a message that is not of the acknowledge class");

   a_tail_zero : assert property (@(posedge clock) disable iff (reset)
      (valid_ff && msg_ff.length < 3'd4) |-> (msg_ff.bytes[3] == '0))
      else $error("byte past message length is not zero");

endmodule

FILE: sv/keybed_message_framer.sv
// keybed_message_framer: top level; frames received bytes into messages and
// emits one result per completed message. Depends on kmf_pkg, kmf_csr,
// kmf_framer and kmf_dispatch.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | req_rx_byte
//   rsp     | out       | rsp_valid/rsp_stall | message bytes, length, dispatch flags
//   csr     | in        | csr_write_enable    | csr_index, csr_write_data
//
// one request per cycle while req_stall is low; a completing byte shows up on rsp in the cycle after it is taken
// the framing state updates in the same cycle the request is taken
// req_stall is high only while a result is held and rsp_stall is high
// reset clears framing state, the result valid and all csr registers

module keybed_message_framer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [kmf_pkg::BYTE_W-1:0]      req_rx_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [kmf_pkg::BYTE_W-1:0]      rsp_byte_zero,
   output logic [kmf_pkg::BYTE_W-1:0]      rsp_byte_one,
   output logic [kmf_pkg::BYTE_W-1:0]      rsp_byte_two,
   output logic [kmf_pkg::BYTE_W-1:0]      rsp_byte_three,
   output logic [kmf_pkg::LEN_W-1:0]       rsp_msg_length,
   output logic                            rsp_enqueue,
   output logic                            rsp_heartbeat,
   output logic                            rsp_handshake_ack,
   output logic [kmf_pkg::STATUS_W-1:0]    rsp_status_word,
   input  logic                            csr_write_enable,
   input  logic [kmf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [kmf_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   kmf_pkg::cfg_type cfg;
   kmf_pkg::msg_type msg;
   logic             req_accept;
   logic             done;

   // result register frees up in the same cycle it is taken
   assign req_stall = rsp_valid && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   kmf_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   kmf_framer u_framer (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_accept),
      .rx_byte (req_rx_byte),
      .done    (done),
      .msg     (msg)
   );

   kmf_dispatch u_dispatch (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .load              (req_accept && done),
      .msg               (msg),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_byte_zero     (rsp_byte_zero),
      .rsp_byte_one      (rsp_byte_one),
      .rsp_byte_two      (rsp_byte_two),
      .rsp_byte_three    (rsp_byte_three),
      .rsp_msg_length    (rsp_msg_length),
      .rsp_enqueue       (rsp_enqueue),
      .rsp_heartbeat     (rsp_heartbeat),
      .rsp_handshake_ack (rsp_handshake_ack),
      .rsp_status_word   (rsp_status_word)
   );

endmodule
